[design/wgpd_pkg.sv]
// Package for the WOFF2 glyph point decoder: error codes, triplet code
// boundaries, glyf flag bits and the triplet decode and flag helper functions.
// No dependencies.
package wgpd_pkg;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_DELTA = 2'd1,
    ERR_COORD = 2'd2
  } err_e;

  // Triplet code ranges (low 7 bits of the flag byte)
  localparam logic [6:0] CODE_X_START   = 7'd10;
  localparam logic [6:0] CODE_PAIR_START = 7'd20;
  localparam logic [6:0] CODE_MID_START = 7'd84;
  localparam logic [6:0] CODE_WIDE_START = 7'd120;
  localparam logic [6:0] CODE_FULL_START = 7'd124;
  localparam logic [5:0] MID_GROUP      = 6'd12;

  localparam logic [2:0] USED_ONE   = 3'd1;
  localparam logic [2:0] USED_TWO   = 3'd2;
  localparam logic [2:0] USED_THREE = 3'd3;
  localparam logic [2:0] USED_FOUR  = 3'd4;

  localparam logic [7:0] GF_ON_CURVE = 8'h01;
  localparam logic [7:0] GF_OVERLAP  = 8'h40;

  localparam logic signed [16:0] S16_MAX = 17'sd32767;
  localparam logic signed [16:0] S16_MIN = -17'sd32768;
  localparam logic signed [15:0] SHORT_MAX = 16'sd255;
  localparam logic signed [15:0] SHORT_MIN = -16'sd255;

  typedef struct packed {
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic [2:0]         used;
  } dec_t;

  function automatic logic signed [16:0] apply_sign(logic pos, logic [15:0] mag);
    logic signed [16:0] m;
    m = $signed({1'b0, mag});
    return pos ? m : -m;
  endfunction

  function automatic dec_t decode_triplet(logic [6:0] f, logic [7:0] b0, logic [7:0] b1,
                                          logic [7:0] b2, logic [7:0] b3);
    dec_t       r;
    logic [15:0] mag_x;
    logic [15:0] mag_y;
    logic       sign_y;
    logic [6:0] b;
    logic [1:0] q;
    logic [5:0] rem;
    mag_x  = '0;
    mag_y  = '0;
    sign_y = f[1];
    b      = '0;
    q      = '0;
    rem    = '0;
    r.used = USED_ONE;
    if (f < CODE_X_START) begin
      sign_y = f[0];
      mag_y  = {5'd0, f[3:1], 8'd0} + {8'd0, b0};
    end else if (f < CODE_PAIR_START) begin
      b     = f - CODE_X_START;
      mag_x = {5'd0, b[3:1], 8'd0} + {8'd0, b0};
    end else if (f < CODE_MID_START) begin
      b     = f - CODE_PAIR_START;
      mag_x = 16'd1 + {10'd0, b[5:4], 4'd0} + {12'd0, b0[7:4]};
      mag_y = 16'd1 + {10'd0, b[3:2], 4'd0} + {12'd0, b0[3:0]};
    end else if (f < CODE_WIDE_START) begin
      b = f - CODE_MID_START;
      if (b[5:0] < MID_GROUP) begin
        q   = 2'd0;
        rem = b[5:0];
      end else if (b[5:0] < (MID_GROUP << 1)) begin
        q   = 2'd1;
        rem = b[5:0] - MID_GROUP;
      end else begin
        q   = 2'd2;
        rem = b[5:0] - (MID_GROUP << 1);
      end
      mag_x  = 16'd1 + {6'd0, q, 8'd0} + {8'd0, b0};
      mag_y  = 16'd1 + {6'd0, rem[3:2], 8'd0} + {8'd0, b1};
      r.used = USED_TWO;
    end else if (f < CODE_FULL_START) begin
      mag_x  = {4'd0, b0, 4'd0} + {12'd0, b1[7:4]};
      mag_y  = {4'd0, b1[3:0], 8'd0} + {8'd0, b2};
      r.used = USED_THREE;
    end else begin
      mag_x  = {b0, b1};
      mag_y  = {b2, b3};
      r.used = USED_FOUR;
    end
    r.dx = apply_sign(f[0], mag_x);
    r.dy = apply_sign(sign_y, mag_y);
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(logic signed [16:0] v);
    if (v > S16_MAX) return 16'sh7FFF;
    if (v < S16_MIN) return 16'sh8000;
    return v[15:0];
  endfunction

  // {same_or_positive, short}
  function automatic logic [1:0] axis_bits(logic signed [15:0] d);
    if (d == 16'sd0) return 2'b10;
    if (d >= SHORT_MIN && d <= SHORT_MAX) return {d > 16'sd0, 1'b1};
    return 2'b00;
  endfunction

endpackage

[design/woff2_glyph_point_decoder.sv]
// WOFF2 glyph point decoder top level: input register, triplet decode,
// running coordinate and bounding box update, result register.
// Depends on wgpd_pkg.
//
// Usage: one beat on the input channel carries a triplet flag byte, four
// data bytes (only bytes_used of them matter), the first-point mark and the
// glyph overlap bit. One beat on the output channel carries the decoded
// deltas, on-curve bit, byte count, glyf flag byte, running absolute
// coordinates, bounding box and sticky error code.
// An accepted point is held in the input register, then registered into the
// result register; throughput is one point per cycle while the output does
// not stall. The rate is set by the combinational path from the input
// register through decode, the 17-bit coordinate add and the box compares
// into the result register, which also updates the running state.
// A stall on the output holds the result register; the input register then
// fills and in_stall_o rises, so at most two points are in flight.
// Reset clears the valid bits, the coordinates, the box and the error.
module woff2_glyph_point_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  point_flag_i,
  input  logic [7:0]  data_byte0_i,
  input  logic [7:0]  data_byte1_i,
  input  logic [7:0]  data_byte2_i,
  input  logic [7:0]  data_byte3_i,
  input  logic        first_point_i,
  input  logic        overlap_glyph_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [15:0] delta_x_o,
  output logic signed [15:0] delta_y_o,
  output logic        on_outline_o,
  output logic [2:0]  bytes_used_o,
  output logic [7:0]  glyf_flag_o,
  output logic signed [15:0] abs_x_o,
  output logic signed [15:0] abs_y_o,
  output logic signed [15:0] box_x_min_o,
  output logic signed [15:0] box_y_min_o,
  output logic signed [15:0] box_x_max_o,
  output logic signed [15:0] box_y_max_o,
  output logic [1:0]  error_code_o
);
  import wgpd_pkg::*;

  // Input register
  logic       in_vld_q;
  logic [7:0] flag_q, b0_q, b1_q, b2_q, b3_q;
  logic       first_q, overlap_q;

  // Running state
  logic signed [15:0] cur_x_q, cur_y_q, min_x_q, min_y_q, max_x_q, max_y_q;
  logic signed [15:0] cur_x_d, cur_y_d, min_x_d, min_y_d, max_x_d, max_y_d;
  err_e               fail_q, err_d;

  // Result register
  logic               out_vld_q;
  logic signed [15:0] dx_q, dy_q;
  logic               on_q;
  logic [2:0]         used_q;
  logic [7:0]         gflag_q;
  err_e               err_q;

  logic in_fire, res_fire, res_ready, in_ready;

  dec_t               dec;
  logic signed [15:0] dx_sat, dy_sat, base_x, base_y;
  logic signed [16:0] nx, ny;
  err_e               fail_base;
  logic               delta_err, coord_err, ok;
  logic [1:0]         ax_bits, ay_bits;
  logic [7:0]         gflag_d;

  assign res_ready  = !out_vld_q || !out_stall_i;
  assign res_fire   = in_vld_q && res_ready;
  assign in_ready   = !in_vld_q || res_ready;
  assign in_stall_o = !in_ready;
  assign in_fire    = in_valid_i && in_ready;

  always_comb begin
    dec       = decode_triplet(flag_q[6:0], b0_q, b1_q, b2_q, b3_q);
    delta_err = (dec.dx > S16_MAX) || (dec.dx < S16_MIN) ||
                (dec.dy > S16_MAX) || (dec.dy < S16_MIN);
    dx_sat    = sat16(dec.dx);
    dy_sat    = sat16(dec.dy);

    // A first point restarts the glyph before it is applied
    base_x    = first_q ? 16'sd0 : cur_x_q;
    base_y    = first_q ? 16'sd0 : cur_y_q;
    fail_base = first_q ? ERR_NONE : fail_q;

    nx        = {base_x[15], base_x} + {dx_sat[15], dx_sat};
    ny        = {base_y[15], base_y} + {dy_sat[15], dy_sat};
    coord_err = (nx > S16_MAX) || (nx < S16_MIN) || (ny > S16_MAX) || (ny < S16_MIN);

    if (fail_base != ERR_NONE) begin
      err_d = fail_base;
    end else if (delta_err) begin
      err_d = ERR_DELTA;
    end else if (coord_err) begin
      err_d = ERR_COORD;
    end else begin
      err_d = ERR_NONE;
    end
    ok = (err_d == ERR_NONE);

    cur_x_d = ok ? nx[15:0] : base_x;
    cur_y_d = ok ? ny[15:0] : base_y;
    min_x_d = min_x_q;
    min_y_d = min_y_q;
    max_x_d = max_x_q;
    max_y_d = max_y_q;
    if (ok) begin
      if (first_q || $signed(nx[15:0]) < min_x_q) min_x_d = nx[15:0];
      if (first_q || $signed(nx[15:0]) > max_x_q) max_x_d = nx[15:0];
      if (first_q || $signed(ny[15:0]) < min_y_q) min_y_d = ny[15:0];
      if (first_q || $signed(ny[15:0]) > max_y_q) max_y_d = ny[15:0];
    end

    ax_bits = axis_bits(dx_sat);
    ay_bits = axis_bits(dy_sat);
    gflag_d = {2'b00, ay_bits[1], ax_bits[1], 1'b0, ay_bits[0], ax_bits[0], 1'b0};
    if (!flag_q[7]) gflag_d = gflag_d | GF_ON_CURVE;
    if (first_q && overlap_q) gflag_d = gflag_d | GF_OVERLAP;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      cur_x_q   <= '0;
      cur_y_q   <= '0;
      min_x_q   <= '0;
      min_y_q   <= '0;
      max_x_q   <= '0;
      max_y_q   <= '0;
      fail_q    <= ERR_NONE;
    end else begin
      if (in_fire) begin
        in_vld_q <= 1'b1;
      end else if (res_fire) begin
        in_vld_q <= 1'b0;
      end
      if (res_fire) begin
        out_vld_q <= 1'b1;
        cur_x_q   <= cur_x_d;
        cur_y_q   <= cur_y_d;
        min_x_q   <= min_x_d;
        min_y_q   <= min_y_d;
        max_x_q   <= max_x_d;
        max_y_q   <= max_y_d;
        fail_q    <= err_d;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      flag_q    <= point_flag_i;
      b0_q      <= data_byte0_i;
      b1_q      <= data_byte1_i;
      b2_q      <= data_byte2_i;
      b3_q      <= data_byte3_i;
      first_q   <= first_point_i;
      overlap_q <= overlap_glyph_i;
    end
    if (res_fire) begin
      dx_q    <= dx_sat;
      dy_q    <= dy_sat;
      on_q    <= !flag_q[7];
      used_q  <= dec.used;
      gflag_q <= gflag_d;
      err_q   <= err_d;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign delta_x_o    = dx_q;
  assign delta_y_o    = dy_q;
  assign on_outline_o = on_q;
  assign bytes_used_o = used_q;
  assign glyf_flag_o  = gflag_q;
  // Running state is only written with a result, so it mirrors the result
  assign abs_x_o      = cur_x_q;
  assign abs_y_o      = cur_y_q;
  assign box_x_min_o  = min_x_q;
  assign box_y_min_o  = min_y_q;
  assign box_x_max_o  = max_x_q;
  assign box_y_max_o  = max_y_q;
  assign error_code_o = err_q;

  // Sticky error freezes the coordinates until a first point
  a_sticky_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_fire && !first_q && fail_q != ERR_NONE) |=> $stable(cur_x_q) && $stable(cur_y_q))
    else $error("coordinates moved under a sticky error");

  // A failing point leaves the box alone
  a_err_box: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_fire && err_d != ERR_NONE) |=> $stable(min_x_q) && $stable(max_x_q) &&
                                        $stable(min_y_q) && $stable(max_y_q))
    else $error("box changed on a failing point");

  a_box_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (min_x_q <= max_x_q) && (min_y_q <= max_y_q))
    else $error("bounding box inverted");

  a_used_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (used_q != 3'd0) && (used_q <= USED_FOUR))
    else $error("bytes used out of range");

endmodule

[sim/woff2_glyph_point_decoder_test.sv]
// Self-checking testbench for woff2_glyph_point_decoder: directed and random glyph
// points with random idling on the input and back-pressure on the output, checked beat by beat.
// Depends on wgpd_pkg and the woff2_glyph_point_decoder RTL.
module woff2_glyph_point_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;
  import wgpd_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 10;
  localparam int HOLD_CYCLES  = 300;

  localparam logic [7:0] GF_X_SHORT = 8'h02;
  localparam logic [7:0] GF_Y_SHORT = 8'h04;
  localparam logic [7:0] GF_X_SAME  = 8'h10;
  localparam logic [7:0] GF_Y_SAME  = 8'h20;

  typedef struct {
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic               on;
    logic [2:0]         used;
    logic [7:0]         gflag;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] xmin;
    logic signed [15:0] ymin;
    logic signed [15:0] xmax;
    logic signed [15:0] ymax;
    err_e               err;
  } point_result_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [7:0]        point_flag_i;
  logic [7:0]        data_byte0_i;
  logic [7:0]        data_byte1_i;
  logic [7:0]        data_byte2_i;
  logic [7:0]        data_byte3_i;
  logic              first_point_i;
  logic              overlap_glyph_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic signed [15:0] delta_x_o;
  logic signed [15:0] delta_y_o;
  logic              on_outline_o;
  logic [2:0]        bytes_used_o;
  logic [7:0]        glyf_flag_o;
  logic signed [15:0] abs_x_o;
  logic signed [15:0] abs_y_o;
  logic signed [15:0] box_x_min_o;
  logic signed [15:0] box_y_min_o;
  logic signed [15:0] box_x_max_o;
  logic signed [15:0] box_y_max_o;
  logic [1:0]        error_code_o;

  // Predictor state: pen position, glyph extent and sticky glyph error
  logic signed [15:0] pen_x, pen_y;
  logic signed [15:0] ext_x_min, ext_y_min, ext_x_max, ext_y_max;
  err_e               glyph_err;

  point_result_t pending_points[$];
  bit  idle_en = 1'b1;
  int  hold_request = 0;
  int  cycle_count = 0;
  int  mismatches = 0;
  int  points_sent = 0;
  int  glyphs_sent = 0;
  int  results_checked = 0;
  int  delta_err_seen = 0;
  int  coord_err_seen = 0;

  woff2_glyph_point_decoder dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .point_flag_i    (point_flag_i),
    .data_byte0_i    (data_byte0_i),
    .data_byte1_i    (data_byte1_i),
    .data_byte2_i    (data_byte2_i),
    .data_byte3_i    (data_byte3_i),
    .first_point_i   (first_point_i),
    .overlap_glyph_i (overlap_glyph_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .delta_x_o       (delta_x_o),
    .delta_y_o       (delta_y_o),
    .on_outline_o    (on_outline_o),
    .bytes_used_o    (bytes_used_o),
    .glyf_flag_o     (glyf_flag_o),
    .abs_x_o         (abs_x_o),
    .abs_y_o         (abs_y_o),
    .box_x_min_o     (box_x_min_o),
    .box_y_min_o     (box_y_min_o),
    .box_x_max_o     (box_x_max_o),
    .box_y_max_o     (box_y_max_o),
    .error_code_o    (error_code_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_points.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic signed [15:0] sat_delta(int v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic logic [7:0] axis_flag(int d, logic [7:0] short_bit, logic [7:0] same_bit);
    if (d == 0) return same_bit;
    if (d >= -255 && d <= 255) return short_bit | ((d > 0) ? same_bit : 8'h00);
    return 8'h00;
  endfunction

  // Decode one point and advance the pen, extent and sticky error
  function automatic point_result_t decode_point(logic [7:0] flag, logic [7:0] b0,
                                                 logic [7:0] b1, logic [7:0] b2,
                                                 logic [7:0] b3, logic first, logic overlap);
    point_result_t r;
    int   c, k, v0, v1, v2, v3, mag_x, mag_y, dx, dy, nx, ny;
    bit   pos_x, pos_y;
    err_e err;
    c = int'(flag[6:0]);
    v0 = int'(b0);
    v1 = int'(b1);
    v2 = int'(b2);
    v3 = int'(b3);
    pos_x = flag[0];
    pos_y = flag[1];
    mag_x = 0;
    mag_y = 0;
    if (c < int'(CODE_X_START)) begin
      pos_y  = flag[0];
      mag_y  = ((c & 14) << 7) + v0;
      r.used = USED_ONE;
    end else if (c < int'(CODE_PAIR_START)) begin
      mag_x  = (((c - int'(CODE_X_START)) & 14) << 7) + v0;
      r.used = USED_ONE;
    end else if (c < int'(CODE_MID_START)) begin
      k      = c - int'(CODE_PAIR_START);
      mag_x  = 1 + (k & 'h30) + (v0 >> 4);
      mag_y  = 1 + ((k & 'h0C) << 2) + (v0 & 'h0F);
      r.used = USED_ONE;
    end else if (c < int'(CODE_WIDE_START)) begin
      k      = c - int'(CODE_MID_START);
      mag_x  = 1 + ((k / int'(MID_GROUP)) << 8) + v0;
      mag_y  = 1 + (((k % int'(MID_GROUP)) >> 2) << 8) + v1;
      r.used = USED_TWO;
    end else if (c < int'(CODE_FULL_START)) begin
      mag_x  = (v0 << 4) + (v1 >> 4);
      mag_y  = ((v1 & 'h0F) << 8) + v2;
      r.used = USED_THREE;
    end else begin
      mag_x  = (v0 << 8) + v1;
      mag_y  = (v2 << 8) + v3;
      r.used = USED_FOUR;
    end
    dx = pos_x ? mag_x : -mag_x;
    dy = pos_y ? mag_y : -mag_y;

    if (first) begin
      pen_x     = '0;
      pen_y     = '0;
      glyph_err = ERR_NONE;
    end

    err = ERR_NONE;
    if (dx < -32768 || dx > 32767 || dy < -32768 || dy > 32767) err = ERR_DELTA;
    r.dx = sat_delta(dx);
    r.dy = sat_delta(dy);
    dx = int'(r.dx);
    dy = int'(r.dy);

    if (glyph_err != ERR_NONE) begin
      err = glyph_err;
    end else if (err == ERR_NONE) begin
      nx = int'(pen_x) + dx;
      ny = int'(pen_y) + dy;
      if (nx < -32768 || nx > 32767 || ny < -32768 || ny > 32767) begin
        err = ERR_COORD;
      end else begin
        pen_x = nx[15:0];
        pen_y = ny[15:0];
        if (first) begin
          ext_x_min = pen_x;
          ext_x_max = pen_x;
          ext_y_min = pen_y;
          ext_y_max = pen_y;
        end else begin
          if (pen_x < ext_x_min) ext_x_min = pen_x;
          if (pen_x > ext_x_max) ext_x_max = pen_x;
          if (pen_y < ext_y_min) ext_y_min = pen_y;
          if (pen_y > ext_y_max) ext_y_max = pen_y;
        end
      end
    end
    glyph_err = err;

    r.on    = ~flag[7];
    r.gflag = r.on ? GF_ON_CURVE : 8'h00;
    if (first && overlap) r.gflag |= GF_OVERLAP;
    r.gflag |= axis_flag(dx, GF_X_SHORT, GF_X_SAME);
    r.gflag |= axis_flag(dy, GF_Y_SHORT, GF_Y_SAME);
    r.ax   = pen_x;
    r.ay   = pen_y;
    r.xmin = ext_x_min;
    r.ymin = ext_y_min;
    r.xmax = ext_x_max;
    r.ymax = ext_y_max;
    r.err  = err;
    return r;
  endfunction

  // Offer one point beat; predict it once the decoder takes it
  task automatic send_point(input logic [7:0] flag, input logic [7:0] b0,
                            input logic [7:0] b1, input logic [7:0] b2,
                            input logic [7:0] b3, input logic first, input logic overlap);
    logic took;
    while (idle_en && $urandom_range(99) < 36) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    point_flag_i    <= flag;
    data_byte0_i    <= b0;
    data_byte1_i    <= b1;
    data_byte2_i    <= b2;
    data_byte3_i    <= b3;
    first_point_i   <= first;
    overlap_glyph_i <= overlap;
    took = 1'b0;
    while (!took) begin
      @(negedge clk_i);
      took = !in_stall_o;
      @(posedge clk_i);
    end
    pending_points.insert(pending_points.size(),
                          decode_point(flag, b0, b1, b2, b3, first, overlap));
    points_sent++;
    if (first) glyphs_sent++;
  endtask

  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk_i);
  endtask

  // Mostly small codes so glyphs run for a while; full-width codes now and then
  task automatic send_random_point(input logic first);
    logic [6:0] code;
    logic [7:0] b0;
    b0 = 8'($urandom_range(255));
    if ($urandom_range(99) < 94) begin
      code = 7'($urandom_range(int'(CODE_FULL_START) - 1));
    end else begin
      code = 7'($urandom_range(127, int'(CODE_FULL_START)));
      if ($urandom_range(1)) b0 = 8'($urandom_range(8'h7F));
    end
    send_point({1'($urandom_range(1)), code}, b0, 8'($urandom_range(255)),
               8'($urandom_range(255)), 8'($urandom_range(255)), first,
               1'($urandom_range(1)));
  endtask

  task automatic send_random_glyphs(input int n_points);
    int left, run;
    left = n_points;
    while (left > 0) begin
      run = $urandom_range(24, 1);
      // A tenth of the runs lack their opening point
      send_random_point($urandom_range(9) != 0);
      left--;
      for (int i = 1; i < run && left > 0; i++) begin
        send_random_point(1'b0);
        left--;
      end
    end
  endtask

  task automatic test_directed();
    // Before any first point the box grows from the origin
    send_point(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
    send_point(8'h89, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1);
    send_point(8'h0A, 8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0);
    send_point(8'h93, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
    send_point(8'h14, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
    send_point(8'hD3, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
    send_point(8'h54, 8'h00, 8'hFF, 8'h00, 8'h00, 1'b0, 1'b0);
    send_point(8'hF7, 8'hFF, 8'hFF, 8'h00, 8'h00, 1'b0, 1'b0);
    send_point(8'h78, 8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b0, 1'b0);
    send_point(8'hFB, 8'h12, 8'h34, 8'h56, 8'h00, 1'b0, 1'b0);
    send_point(8'h7C, 8'h01, 8'h02, 8'h03, 8'h04, 1'b0, 1'b0);
    // First point with overlap at the positive corner, then push x past it
    send_point(8'h7F, 8'h7F, 8'hFF, 8'h7F, 8'hFF, 1'b1, 1'b1);
    send_point(8'h15, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
    // Sticky error holds the state; overlap ignored off the first point
    send_point(8'h00, 8'h05, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1);
    // Delta beyond 16 bits on a first point, then stays sticky
    send_point(8'hFD, 8'hFF, 8'hFF, 8'h00, 8'h00, 1'b1, 1'b1);
    send_point(8'h01, 8'h10, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
    // Most negative delta is legal; one more step down overflows the coordinate
    send_point(8'h7C, 8'h80, 8'h00, 8'h80, 8'h00, 1'b1, 1'b0);
    send_point(8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
    // Delta error wins over a coordinate that would also overflow
    send_point(8'h7F, 8'h7F, 8'hFF, 8'h00, 8'h00, 1'b1, 1'b0);
    send_point(8'h7D, 8'hFF, 8'hFF, 8'h00, 8'h00, 1'b0, 1'b0);
    send_point(8'h7E, 8'h00, 8'h00, 8'hFF, 8'hFF, 1'b1, 1'b0);
    send_point(8'h20, 8'hA5, 8'h5A, 8'hC3, 8'h3C, 1'b1, 1'b1);
    wait_results_drained();
  endtask

  task automatic test_random_idling();
    send_random_glyphs(380);
  endtask

  task automatic test_no_idling();
    idle_en = 1'b0;
    send_random_glyphs(150);
    idle_en = 1'b1;
  endtask

  task automatic test_output_hold();
    hold_request = HOLD_CYCLES;
    send_random_glyphs(40);
    wait_results_drained();
  endtask

  task automatic test_sender_pause();
    send_random_glyphs(60);
    wait_results_drained();
    send_random_glyphs(50);
  endtask

  // Receiver: random stall, or a counted hold when one is requested
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= idle_en && ($urandom_range(99) < 36);
      end
    end
  end

  function automatic void check_field(string field, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endfunction

  // Outputs are settled at the falling edge; a beat seen here is taken at the next rise
  initial begin
    point_result_t exp_pt;
    forever begin
      @(negedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (pending_points.size() == 0) begin
          $error("result beat with no point outstanding");
          mismatches++;
        end else begin
          exp_pt = pending_points.pop_front();
          check_field("delta_x", int'(exp_pt.dx), int'(delta_x_o));
          check_field("delta_y", int'(exp_pt.dy), int'(delta_y_o));
          check_field("on_outline", int'(exp_pt.on), int'(on_outline_o));
          check_field("bytes_used", int'(exp_pt.used), int'(bytes_used_o));
          check_field("glyf_flag", int'(exp_pt.gflag), int'(glyf_flag_o));
          check_field("abs_x", int'(exp_pt.ax), int'(abs_x_o));
          check_field("abs_y", int'(exp_pt.ay), int'(abs_y_o));
          check_field("box_x_min", int'(exp_pt.xmin), int'(box_x_min_o));
          check_field("box_y_min", int'(exp_pt.ymin), int'(box_y_min_o));
          check_field("box_x_max", int'(exp_pt.xmax), int'(box_x_max_o));
          check_field("box_y_max", int'(exp_pt.ymax), int'(box_y_max_o));
          check_field("error_code", int'(exp_pt.err), int'(error_code_o));
          if (exp_pt.err == ERR_DELTA) delta_err_seen++;
          if (exp_pt.err == ERR_COORD) coord_err_seen++;
          results_checked++;
        end
      end
    end
  end

  initial begin
    pen_x     = '0;
    pen_y     = '0;
    ext_x_min = '0;
    ext_y_min = '0;
    ext_x_max = '0;
    ext_y_max = '0;
    glyph_err = ERR_NONE;
    rst_ni          <= 1'b0;
    in_valid_i      <= 1'b0;
    point_flag_i    <= '0;
    data_byte0_i    <= '0;
    data_byte1_i    <= '0;
    data_byte2_i    <= '0;
    data_byte3_i    <= '0;
    first_point_i   <= 1'b0;
    overlap_glyph_i <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_random_idling();
    test_no_idling();
    test_output_hold();
    test_sender_pause();

    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Decoded %0d points over %0d glyph starts, %0d result beats checked",
             points_sent, glyphs_sent, results_checked);
    $display("Results carrying delta error: %0d, coordinate error: %0d",
             delta_err_seen, coord_err_seen);
    if (mismatches == 0 && pending_points.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
